// ----- sv/tsups_pkg.sv -----
// shared types, constants and helpers of the three-stage unit pool scheduler
`timescale 1ns / 1ps

package tsups_pkg;

  localparam int MAX_UNITS = 1024;
  localparam int HEAD_W    = $clog2(MAX_UNITS);
  localparam int UNIT_W    = HEAD_W + 1;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [UNIT_W-1:0] units_t;
  typedef logic [HEAD_W-1:0] head_t;
  typedef logic [DUR_W-1:0]  dur_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNITS_A = 3'd0,
    REG_UNITS_B = 3'd1,
    REG_UNITS_C = 3'd2,
    REG_DUR_A   = 3'd3,
    REG_DUR_B   = 3'd4,
    REG_DUR_C   = 3'd5
  } cfg_reg_t;

  // per-pool control from the scheduler
  typedef struct packed {
    logic take;   // new job accepted, look up and advance the head
    logic clear;  // job opens a new batch
    logic upd;    // job in the compute stage writes its reservation
  } pool_ctl_t;

  function automatic units_t clamp_units(input units_t u);
    units_t r;
    r = u;
    if (u == '0) begin
      r = units_t'(1);
    end else if (u > units_t'(MAX_UNITS)) begin
      r = units_t'(MAX_UNITS);
    end
    return r;
  endfunction

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

// ----- sv/tsups_pool.sv -----
// one unit pool: ring of free times with head, fill count and read bypass
`timescale 1ns / 1ps

module tsups_pool (
  input  logic                clk,
  input  logic                rst_n,
  input  tsups_pkg::units_t   units,
  input  tsups_pkg::pool_ctl_t ctl,
  input  tsups_pkg::time_t    upd_val,
  output tsups_pkg::time_t    peek_val
);
  import tsups_pkg::*;

  time_t  mem [MAX_UNITS];
  time_t  rd_q;
  head_t  head_r, head_nxt;
  units_t fill_r, fill_nxt;
  head_t  addr_r;
  logic   hit_r;
  logic   byp_r;
  time_t  byp_val_r;

  head_t  head_base;
  units_t fill_base;
  head_t  h;
  units_t h_inc;
  logic   hit;

  always_comb begin
    head_base = ctl.clear ? '0 : head_r;
    fill_base = ctl.clear ? '0 : fill_r;
    // head past the unit count after a count change wraps to zero
    h         = ({1'b0, head_base} >= units) ? '0 : head_base;
    h_inc     = {1'b0, h} + units_t'(1);
    hit       = {1'b0, h} < fill_base;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    if (ctl.take) begin
      head_nxt = (h_inc >= units) ? '0 : h_inc[HEAD_W-1:0];
      fill_nxt = (h_inc > fill_base) ? h_inc : fill_base;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mem[addr_r] <= upd_val;
    end
    if (ctl.take) begin
      rd_q <= mem[h];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entry written by the job leaving compute in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      addr_r    <= h;
      hit_r     <= hit;
      byp_r     <= ctl.upd && (h == addr_r);
      byp_val_r <= upd_val;
    end
  end

  assign peek_val = !hit_r ? '0 : (byp_r ? byp_val_r : rd_q);

endmodule

// ----- sv/three_stage_unit_pool_scheduler.sv -----
// top level of the three-stage unit pool scheduler
`timescale 1ns / 1ps

// Greedy flow-shop scheduler over three pools of identical units.
// Input channel in_valid/in_stall carries one job per transaction; in_new_batch
// clears all pools and the makespan before that job is scheduled.
// Result channel out_valid/out_stall carries job start, finish and makespan,
// one result transaction per job, in order.
// Configuration channel cfg_valid/cfg_ready writes unit counts (index 0..2) and
// stage durations (index 3..5); cfg_ready is always high, other indexes are
// ignored. Write configuration only while the block holds no job.
// A job accepted has its ring read at accept and is held in the compute stage;
// it is then computed, written to the ring and registered for the result port.
// Throughput: one job per cycle unless the result stalls; each pool's ring head
// advances at accept, and a pending reservation is forwarded to the next lookup.
// Reset: pools empty, makespan zero, config registers at one; no clearing pass,
// each ring keeps a fill count and unwritten entries read as zero.
// A stalled result holds the output register; the compute stage fills behind
// it and then in_stall rises until the result is taken.
module three_stage_unit_pool_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_batch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_job_start,
  output logic [31:0]                   out_job_finish,
  output logic [31:0]                   out_makespan,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsups_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsups_pkg::DUR_W-1:0]   cfg_data
);
  import tsups_pkg::*;

  units_t units_a_r, units_b_r, units_c_r;
  dur_t   dur_a_r, dur_b_r, dur_c_r;
  units_t ua, ub, uc;

  logic   s1_valid_r;
  logic   s1_nb_r;
  logic   s1_fire;
  logic   in_take;
  logic   out_valid_r;
  time_t  start_r, finish_r, makespan_r;
  time_t  longest_r;

  pool_ctl_t ctl;
  time_t  ma, mb, mc;
  time_t  lead1, lead2, lead3;
  time_t  cb, cc, f, ea, eb, ec, lf_base, mk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_a_r <= units_t'(1);
      units_b_r <= units_t'(1);
      units_c_r <= units_t'(1);
      dur_a_r   <= dur_t'(1);
      dur_b_r   <= dur_t'(1);
      dur_c_r   <= dur_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UNITS_A: units_a_r <= cfg_data[UNIT_W-1:0];
        REG_UNITS_B: units_b_r <= cfg_data[UNIT_W-1:0];
        REG_UNITS_C: units_c_r <= cfg_data[UNIT_W-1:0];
        REG_DUR_A:   dur_a_r   <= cfg_data;
        REG_DUR_B:   dur_b_r   <= cfg_data;
        REG_DUR_C:   dur_c_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ua = clamp_units(units_a_r);
  assign ub = clamp_units(units_b_r);
  assign uc = clamp_units(units_c_r);

  // handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  assign ctl.take  = in_take;
  assign ctl.clear = in_new_batch;
  assign ctl.upd   = s1_fire;

  tsups_pool u_pool_a (.clk, .rst_n, .units(ua), .ctl, .upd_val(ea), .peek_val(ma));
  tsups_pool u_pool_b (.clk, .rst_n, .units(ub), .ctl, .upd_val(eb), .peek_val(mb));
  tsups_pool u_pool_c (.clk, .rst_n, .units(uc), .ctl, .upd_val(ec), .peek_val(mc));

  // offsets from job start to entry of each stage boundary; never saturate
  always_comb begin
    lead1   = time_t'(dur_a_r);
    lead2   = time_t'(dur_a_r) + time_t'(dur_b_r);
    lead3   = lead2 + time_t'(dur_c_r);
    cb      = (mb > lead1) ? mb - lead1 : '0;
    cc      = (mc > lead2) ? mc - lead2 : '0;
    f       = ma;
    if (cb > f) begin
      f = cb;
    end
    if (cc > f) begin
      f = cc;
    end
    ea      = sat_add(f, lead1);
    eb      = sat_add(f, lead2);
    ec      = sat_add(f, lead3);
    lf_base = s1_nb_r ? '0 : longest_r;
    mk      = (ec > lf_base) ? ec : lf_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      longest_r   <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        longest_r   <= mk;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_nb_r <= in_new_batch;
    end
    if (s1_fire) begin
      start_r    <= f;
      finish_r   <= ec;
      makespan_r <= mk;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_job_start  = start_r;
  assign out_job_finish = finish_r;
  assign out_makespan   = makespan_r;

`ifndef SYNTHESIS
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with compute stage free");

  a_finish_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> finish_r >= start_r)
    else $error("job finish before job start");

  a_makespan_covers_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> makespan_r >= finish_r)
    else $error("makespan below job finish");

  a_result_follows_compute: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("computed job did not reach output register");
`endif

endmodule
